// ===== hw/rtl/talg_pkg.sv =====
// shared constants, types and helpers for the average linkage grouper
`default_nettype none

package talg_pkg;

    // component count and derived widths
    localparam int MAXC     = 32;
    localparam int IDX_W    = $clog2(MAXC);
    localparam int CNT_W    = $clog2(MAXC + 1);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAXC * MAXC;
    localparam int DIST_W   = 17;
    localparam int PS_W     = DIST_W + ADDR_W;
    localparam int SZP_W    = 2 * CNT_W;
    localparam int MB_W     = (SZP_W > DIST_W) ? SZP_W : DIST_W;
    localparam int PROD_W   = PS_W + MB_W;
    localparam int VAR_W    = 21;
    localparam logic [VAR_W-1:0] VAR_SAT = {VAR_W{1'b1}};

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD_CORR = 2'd0,
        CMD_LOAD_VAR  = 2'd1,
        CMD_RUN       = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    // flat address of a matrix entry
    function automatic logic [ADDR_W-1:0] pair_addr(input logic [IDX_W-1:0] r,
                                                    input logic [IDX_W-1:0] c);
        pair_addr = ADDR_W'(r) * ADDR_W'(MAXC) + ADDR_W'(c);
    endfunction

    // distance one minus a Q1.15 value, in units of 2^-15
    function automatic logic [DIST_W-1:0] one_minus(input logic [15:0] v);
        one_minus = DIST_W'(17'd32768) - {v[15], v};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/talg_mult.sv =====
// shared registered multiplier for the linkage compares
`default_nettype none

module talg_mult (
    input  wire logic                           clk,
    input  wire logic [talg_pkg::PS_W-1:0]      op_a,
    input  wire logic [talg_pkg::MB_W-1:0]      op_b,
    output logic      [talg_pkg::PROD_W-1:0]    prod
);

    logic [talg_pkg::PROD_W-1:0] prod_reg;

    // one product per cycle, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= talg_pkg::PROD_W'(op_a) * talg_pkg::PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_average_linkage_grouper.sv =====
// top level: stores, merge sequencer, ranking and result stream
//
// Usage: a beat is taken when start is high and busy is low. Command 0
// writes one correlation entry (row, col, corr_value) and command 1 one
// variance fraction (row, var_fraction); neither raises busy. Command 2
// runs the clustering over item_count components (saturated to 32);
// item_count 0 is dropped. The threshold register is to be written
// through cfg_we / cfg_wdata only while the block is idle; the block
// itself does not enforce this. A run holds busy high while it copies
// distances into the pair-sum memory, then searches the active pairs
// (one shared multiplier serves every cross product, one at a time) and
// skips inactive indices; a pass that finds a pair compares it against
// the cut, then merges the two clusters and folds rows and columns
// through the single pair-sum memory. Then come the variance sums, the
// ranking of every surviving cluster and the pick of the trend group.
// Results follow, one per cycle for components 0..n-1, each shown for
// exactly one cycle with result_valid; the receiver cannot stall them,
// and last marks the final one. busy falls in the cycle of the last one.
// Reset returns the sequencer to idle, the threshold to 0.5, labels to
// their own index and all clusters active; the stores hold no reset.
`default_nettype none

module threshold_average_linkage_grouper (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  command,
    input  wire logic [4:0]  row,
    input  wire logic [4:0]  col,
    input  wire logic [15:0] corr_value,
    input  wire logic [15:0] var_fraction,
    input  wire logic [5:0]  item_count,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             result_valid,
    output logic [4:0]       elem_index,
    output logic [4:0]       group_rank,
    output logic [5:0]       group_number,
    output logic [20:0]      group_var,
    output logic             is_trend,
    output logic             is_noise,
    output logic             last
);

    localparam int MAXC   = talg_pkg::MAXC;
    localparam int IDX_W  = talg_pkg::IDX_W;
    localparam int CNT_W  = talg_pkg::CNT_W;
    localparam int ADDR_W = talg_pkg::ADDR_W;
    localparam int PS_W   = talg_pkg::PS_W;
    localparam int SZP_W  = talg_pkg::SZP_W;
    localparam int MB_W   = talg_pkg::MB_W;
    localparam int PROD_W = talg_pkg::PROD_W;
    localparam int VAR_W  = talg_pkg::VAR_W;
    localparam int DIST_W = talg_pkg::DIST_W;

    typedef enum logic [23:0] {
        ST_IDLE     = 24'h000001,
        ST_BUILD_RD = 24'h000002,
        ST_BUILD_WR = 24'h000004,
        ST_SRCH_I   = 24'h000008,
        ST_SRCH_J   = 24'h000010,
        ST_LD_S     = 24'h000020,
        ST_MUL_B    = 24'h000040,
        ST_CMP      = 24'h000080,
        ST_CUT_MUL  = 24'h000100,
        ST_CUT_CMP  = 24'h000200,
        ST_MERGE    = 24'h000400,
        ST_MERGE_SZ = 24'h000800,
        ST_ROW_RD1  = 24'h001000,
        ST_ROW_RD2  = 24'h002000,
        ST_ROW_WR   = 24'h004000,
        ST_COL_RD1  = 24'h008000,
        ST_COL_RD2  = 24'h010000,
        ST_COL_WR   = 24'h020000,
        ST_VCLR     = 24'h040000,
        ST_VSUM     = 24'h080000,
        ST_RANK_C   = 24'h100000,
        ST_RANK_C2  = 24'h200000,
        ST_TRND     = 24'h400000,
        ST_OUT      = 24'h800000
    } state_t;

    state_t state_reg, state_next;

    // stores
    logic [15:0]       corr_mem [talg_pkg::DEPTH];
    logic [PS_W-1:0]   psum_mem [talg_pkg::DEPTH];
    logic [15:0]       var_mem  [MAXC];
    logic [IDX_W-1:0]  label_reg [MAXC];
    logic              active_reg [MAXC];
    logic [CNT_W-1:0]  size_reg [MAXC];
    logic [VAR_W-1:0]  cvar_reg [MAXC];
    logic [IDX_W-1:0]  rank_reg [MAXC];

    logic [15:0]       corr_rdata_reg;
    logic [PS_W-1:0]   psum_rdata_reg;
    logic [ADDR_W-1:0] corr_raddr, psum_raddr, psum_waddr;
    logic [PS_W-1:0]   psum_wdata;
    logic              psum_we;

    // sequencer registers
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [IDX_W-1:0]  bi_reg, bi_next;
    logic [IDX_W-1:0]  bj_reg, bj_next;
    logic              found_reg, found_next;
    logic [PS_W-1:0]   bs_reg, bs_next;
    logic [SZP_W-1:0]  bc_reg, bc_next;
    logic [CNT_W-1:0]  si_reg, si_next;
    logic [SZP_W-1:0]  c_reg, c_next;
    logic [PROD_W-1:0] pa_reg, pa_next;
    logic [PS_W-1:0]   tmp_reg, tmp_next;
    logic [CNT_W-1:0]  szt_reg, szt_next;
    logic [VAR_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [CNT_W-1:0]  ng_reg, ng_next;
    logic [IDX_W-1:0]  trend_reg, trend_next;
    logic [IDX_W-1:0]  trank_reg, trank_next;
    logic [15:0]       thr_reg;

    // result registers
    logic              rv_reg, rv_next;
    logic [4:0]        ei_reg, ei_next;
    logic [4:0]        gr_reg, gr_next;
    logic [5:0]        gn_reg, gn_next;
    logic [20:0]       gv_reg, gv_next;
    logic              tr_reg, tr_next;
    logic              no_reg, no_next;
    logic              last_reg, last_next;

    // multiplier port
    logic [PS_W-1:0]   mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] mul_p;

    logic [CNT_W-1:0]  n_eff;
    logic              take;
    logic [DIST_W-1:0] cut;
    logic [IDX_W-1:0]  i_idx, j_idx, k_idx;
    logic [IDX_W-1:0]  g_cur;
    logic [VAR_W:0]    vsum;

    assign i_idx = i_reg[IDX_W-1:0];
    assign j_idx = j_reg[IDX_W-1:0];
    assign k_idx = k_reg[IDX_W-1:0];
    assign busy  = (state_reg != ST_IDLE);
    assign take  = start && !busy;
    assign cut   = talg_pkg::one_minus(thr_reg);
    assign g_cur = label_reg[i_idx];
    assign vsum  = {1'b0, cvar_reg[g_cur]} + (VAR_W + 1)'(var_mem[i_idx]);

    // run length, saturated to the store size
    always_comb
    begin
        if (32'(item_count) > 32'(MAXC))
            n_eff = CNT_W'(MAXC);
        else
            n_eff = CNT_W'(item_count);
    end

    talg_mult u_mult (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LD_S:
            begin
                mul_a = psum_rdata_reg;
                mul_b = MB_W'(bc_reg);
            end
            ST_MUL_B:
            begin
                mul_a = bs_reg;
                mul_b = MB_W'(c_reg);
            end
            ST_CUT_MUL:
            begin
                mul_a = PS_W'(bc_reg);
                mul_b = MB_W'(cut);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // memory address select
    always_comb
    begin
        corr_raddr = talg_pkg::pair_addr(i_idx, j_idx);
        psum_raddr = '0;
        psum_waddr = '0;
        psum_wdata = '0;
        psum_we    = 1'b0;
        case (state_reg)
            ST_SRCH_J:   psum_raddr = talg_pkg::pair_addr(i_idx, j_idx);
            ST_ROW_RD1:  psum_raddr = talg_pkg::pair_addr(bj_reg, k_idx);
            ST_ROW_RD2:  psum_raddr = talg_pkg::pair_addr(bi_reg, k_idx);
            ST_COL_RD1:  psum_raddr = talg_pkg::pair_addr(k_idx, bj_reg);
            ST_COL_RD2:  psum_raddr = talg_pkg::pair_addr(k_idx, bi_reg);
            ST_BUILD_WR:
            begin
                psum_we    = 1'b1;
                psum_waddr = talg_pkg::pair_addr(i_idx, j_idx);
                psum_wdata = PS_W'(talg_pkg::one_minus(corr_rdata_reg));
            end
            ST_ROW_WR:
            begin
                psum_we    = 1'b1;
                psum_waddr = talg_pkg::pair_addr(bi_reg, k_idx);
                psum_wdata = psum_rdata_reg + tmp_reg;
            end
            ST_COL_WR:
            begin
                psum_we    = 1'b1;
                psum_waddr = talg_pkg::pair_addr(k_idx, bi_reg);
                psum_wdata = psum_rdata_reg + tmp_reg;
            end
            default:
            begin
                psum_we = 1'b0;
            end
        endcase
    end

    // correlation store: load beats and registered read
    always_ff @(posedge clk)
    begin
        if (take && talg_pkg::cmd_t'(command) == talg_pkg::CMD_LOAD_CORR
            && 32'(row) < 32'(MAXC) && 32'(col) < 32'(MAXC))
            corr_mem[talg_pkg::pair_addr(IDX_W'(row), IDX_W'(col))] <= corr_value;
        corr_rdata_reg <= corr_mem[corr_raddr];
    end

    // pair-sum memory
    always_ff @(posedge clk)
    begin
        if (psum_we)
            psum_mem[psum_waddr] <= psum_wdata;
        psum_rdata_reg <= psum_mem[psum_raddr];
    end

    // variance store, sizes, sums and ranks
    always_ff @(posedge clk)
    begin
        if (take && talg_pkg::cmd_t'(command) == talg_pkg::CMD_LOAD_VAR
            && 32'(row) < 32'(MAXC))
            var_mem[IDX_W'(row)] <= var_fraction;
        if (state_reg == ST_BUILD_WR && j_reg == '0)
            size_reg[i_idx] <= CNT_W'(1);
        if (state_reg == ST_MERGE_SZ)
            size_reg[bi_reg] <= size_reg[bi_reg] + szt_reg;
        if (state_reg == ST_VCLR)
        begin
            for (int m = 0; m < MAXC; m++)
                cvar_reg[m] <= '0;
        end
        if (state_reg == ST_VSUM && i_reg != n_reg)
            cvar_reg[g_cur] <= (vsum > (VAR_W + 1)'(talg_pkg::VAR_SAT))
                               ? talg_pkg::VAR_SAT : vsum[VAR_W-1:0];
        if (state_reg == ST_RANK_C2 && j_reg == n_reg)
            rank_reg[i_idx] <= r_reg;
    end

    // cluster labels and active flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < MAXC; m++)
            begin
                label_reg[m]  <= IDX_W'(m);
                active_reg[m] <= 1'b1;
            end
        end
        else if (take && talg_pkg::cmd_t'(command) == talg_pkg::CMD_RUN && n_eff != '0)
        begin
            for (int m = 0; m < MAXC; m++)
            begin
                label_reg[m]  <= IDX_W'(m);
                active_reg[m] <= (m < 32'(n_eff));
            end
        end
        else if (state_reg == ST_MERGE)
        begin
            for (int m = 0; m < MAXC; m++)
            begin
                if (label_reg[m] == bj_reg)
                    label_reg[m] <= bi_reg;
            end
            active_reg[bj_reg] <= 1'b0;
        end
    end

    // threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= 16'h4000;
        else if (cfg_we)
            thr_reg <= cfg_wdata;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        bi_next    = bi_reg;
        bj_next    = bj_reg;
        found_next = found_reg;
        bs_next    = bs_reg;
        bc_next    = bc_reg;
        si_next    = si_reg;
        c_next     = c_reg;
        pa_next    = pa_reg;
        tmp_next   = tmp_reg;
        szt_next   = szt_reg;
        cur_next   = cur_reg;
        r_next     = r_reg;
        ng_next    = ng_reg;
        trend_next = trend_reg;
        trank_next = trank_reg;
        rv_next    = 1'b0;
        ei_next    = ei_reg;
        gr_next    = gr_reg;
        gn_next    = gn_reg;
        gv_next    = gv_reg;
        tr_next    = tr_reg;
        no_next    = no_reg;
        last_next  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take && talg_pkg::cmd_t'(command) == talg_pkg::CMD_RUN
                    && n_eff != '0)
                begin
                    n_next     = n_eff;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_BUILD_RD;
                end
            end
            // copy distances into the pair-sum memory
            ST_BUILD_RD:
            begin
                state_next = ST_BUILD_WR;
            end
            ST_BUILD_WR:
            begin
                state_next = ST_BUILD_RD;
                if (j_reg + 1'b1 == n_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                    begin
                        i_next     = '0;
                        found_next = 1'b0;
                        state_next = ST_SRCH_I;
                    end
                end
                else
                    j_next = j_reg + 1'b1;
            end
            // pair search, outer index
            ST_SRCH_I:
            begin
                if ({1'b0, i_reg} + 1'b1 >= {1'b0, n_reg})
                    state_next = found_reg ? ST_CUT_MUL : ST_VCLR;
                else if (active_reg[i_idx])
                begin
                    si_next    = size_reg[i_idx];
                    j_next     = i_reg + 1'b1;
                    state_next = ST_SRCH_J;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            // pair search, inner index
            ST_SRCH_J:
            begin
                if (j_reg == n_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SRCH_I;
                end
                else if (!active_reg[j_idx])
                    j_next = j_reg + 1'b1;
                else
                begin
                    c_next     = SZP_W'(si_reg) * SZP_W'(size_reg[j_idx]);
                    state_next = ST_LD_S;
                end
            end
            ST_LD_S:
            begin
                tmp_next   = psum_rdata_reg;
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                pa_next    = mul_p;
                state_next = ST_CMP;
            end
            // cross-multiplied average compare
            ST_CMP:
            begin
                if (!found_reg || pa_reg < mul_p)
                begin
                    found_next = 1'b1;
                    bs_next    = tmp_reg;
                    bc_next    = c_reg;
                    bi_next    = i_idx;
                    bj_next    = j_idx;
                end
                j_next     = j_reg + 1'b1;
                state_next = ST_SRCH_J;
            end
            ST_CUT_MUL:
            begin
                state_next = ST_CUT_CMP;
            end
            ST_CUT_CMP:
            begin
                if (PROD_W'(bs_reg) > mul_p)
                    state_next = ST_VCLR;
                else
                    state_next = ST_MERGE;
            end
            ST_MERGE:
            begin
                szt_next   = size_reg[bj_reg];
                state_next = ST_MERGE_SZ;
            end
            ST_MERGE_SZ:
            begin
                k_next     = '0;
                state_next = ST_ROW_RD1;
            end
            // fold row bj into row bi
            ST_ROW_RD1:
            begin
                state_next = ST_ROW_RD2;
            end
            ST_ROW_RD2:
            begin
                tmp_next   = psum_rdata_reg;
                state_next = ST_ROW_WR;
            end
            ST_ROW_WR:
            begin
                if (k_reg + 1'b1 == n_reg)
                begin
                    k_next     = '0;
                    state_next = ST_COL_RD1;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_ROW_RD1;
                end
            end
            // fold column bj into column bi
            ST_COL_RD1:
            begin
                state_next = ST_COL_RD2;
            end
            ST_COL_RD2:
            begin
                tmp_next   = psum_rdata_reg;
                state_next = ST_COL_WR;
            end
            ST_COL_WR:
            begin
                if (k_reg + 1'b1 == n_reg)
                begin
                    i_next     = '0;
                    found_next = 1'b0;
                    state_next = ST_SRCH_I;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_COL_RD1;
                end
            end
            // group variance sums
            ST_VCLR:
            begin
                i_next     = '0;
                state_next = ST_VSUM;
            end
            ST_VSUM:
            begin
                if (i_reg == n_reg)
                begin
                    i_next     = '0;
                    ng_next    = '0;
                    state_next = ST_RANK_C;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            // rank each active cluster
            ST_RANK_C:
            begin
                if (i_reg == n_reg)
                    state_next = ST_TRND;
                else if (active_reg[i_idx])
                begin
                    cur_next   = cvar_reg[i_idx];
                    r_next     = '0;
                    j_next     = '0;
                    ng_next    = ng_reg + 1'b1;
                    state_next = ST_RANK_C2;
                end
                else
                    i_next = i_reg + 1'b1;
            end
            ST_RANK_C2:
            begin
                if (j_reg == n_reg)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_RANK_C;
                end
                else
                begin
                    if (active_reg[j_idx] && j_reg != i_reg
                        && (cvar_reg[j_idx] > cur_reg
                            || (cvar_reg[j_idx] == cur_reg && j_reg < i_reg)))
                        r_next = r_reg + 1'b1;
                    j_next = j_reg + 1'b1;
                end
            end
            ST_TRND:
            begin
                trend_next = label_reg[0];
                trank_next = rank_reg[label_reg[0]];
                i_next     = '0;
                state_next = ST_OUT;
            end
            // one result beat per component
            ST_OUT:
            begin
                rv_next   = 1'b1;
                ei_next   = 5'(i_idx);
                gr_next   = 5'(rank_reg[g_cur]);
                gv_next   = cvar_reg[g_cur];
                tr_next   = (g_cur == trend_reg);
                no_next   = (g_cur != trend_reg) && (ng_reg > CNT_W'(1))
                            && (CNT_W'(rank_reg[g_cur]) + 1'b1 == ng_reg);
                if (g_cur == trend_reg)
                    gn_next = '0;
                else if (trank_reg < rank_reg[g_cur])
                    gn_next = 6'(CNT_W'(rank_reg[g_cur]));
                else
                    gn_next = 6'(CNT_W'(rank_reg[g_cur]) + 1'b1);
                last_next = (i_reg + 1'b1 == n_reg);
                i_next    = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            last_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            last_reg  <= last_next;
            found_reg <= found_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        bi_reg    <= bi_next;
        bj_reg    <= bj_next;
        bs_reg    <= bs_next;
        bc_reg    <= bc_next;
        si_reg    <= si_next;
        c_reg     <= c_next;
        pa_reg    <= pa_next;
        tmp_reg   <= tmp_next;
        szt_reg   <= szt_next;
        cur_reg   <= cur_next;
        r_reg     <= r_next;
        ng_reg    <= ng_next;
        trend_reg <= trend_next;
        trank_reg <= trank_next;
        ei_reg    <= ei_next;
        gr_reg    <= gr_next;
        gn_reg    <= gn_next;
        gv_reg    <= gv_next;
        tr_reg    <= tr_next;
        no_reg    <= no_next;
    end

    assign result_valid = rv_reg;
    assign elem_index   = ei_reg;
    assign group_rank   = gr_reg;
    assign group_number = gn_reg;
    assign group_var    = gv_reg;
    assign is_trend     = tr_reg;
    assign is_noise     = no_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire
